/* design/mbfifo_pkg.sv */
package mbfifo_pkg;

  localparam int GROUPS     = 2;
  localparam int CHANNELS   = 4;
  localparam int FIFO_DEPTH = 8;

  localparam int NFIFO     = GROUPS * CHANNELS;
  localparam int MEM_DEPTH = NFIFO * FIFO_DEPTH;
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_W    = (NFIFO > 1) ? $clog2(NFIFO) : 1;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int GRP_IW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [7:0] REG_RD_EN   = 8'h20;
  localparam logic [7:0] REG_RD_PEND = 8'h24;
  localparam logic [7:0] REG_WR_EN   = 8'h30;
  localparam logic [7:0] REG_WR_PEND = 8'h34;
  localparam logic [7:0] REG_STATUS  = 8'h60;
  localparam logic [7:0] REG_FIFO    = 8'h70;
  localparam logic [7:0] REG_THRESH  = 8'h80;
  localparam logic [7:0] REG_SPAN    = 8'(4 * CHANNELS);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [9:0]  address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        push_dropped;
    logic        irq;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic out_free;
  } dp_status_t;

endpackage

/* design/mbfifo_ctrl.sv */
module mbfifo_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mbfifo_pkg::dp_status_t status,
  output mbfifo_pkg::ctrl_cmd_t  cmd
);
  import mbfifo_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = status.is_pop ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/mbfifo_dp.sv */
module mbfifo_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  mbfifo_pkg::req_t       in_data,
  input  mbfifo_pkg::ctrl_cmd_t  cmd,
  output mbfifo_pkg::dp_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mbfifo_pkg::rsp_t       out_data
);
  import mbfifo_pkg::*;

  req_t req;

  logic [CNT_W-1:0]    count [NFIFO];
  logic [PTR_W-1:0]    head  [NFIFO];
  logic [1:0]          thr_code [NFIFO];
  logic [CHANNELS-1:0] rd_en   [GROUPS];
  logic [CHANNELS-1:0] rd_pend [GROUPS];
  logic [CHANNELS-1:0] wr_en   [GROUPS];
  logic [CHANNELS-1:0] wr_pend [GROUPS];

  logic [CHANNELS-1:0] rd_en_next   [GROUPS];
  logic [CHANNELS-1:0] rd_pend_next [GROUPS];
  logic [CHANNELS-1:0] wr_en_next   [GROUPS];
  logic [CHANNELS-1:0] wr_pend_next [GROUPS];

  logic [31:0] words [MEM_DEPTH];
  logic [31:0] mem_q;
  logic        mem_we;
  logic        mem_re;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;

  logic [1:0]          grp;
  logic [GRP_IW-1:0]   gi;
  logic [7:0]          off;
  logic                grp_ok;
  logic                in_status, in_fifo, in_thresh;
  logic [7:0]          rel;
  logic [CH_W-1:0]     ch;
  logic [FIFO_W-1:0]   f;
  logic                is_wr;
  logic [CNT_W-1:0]    cnt;
  logic [PTR_W-1:0]    hd;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W:0]      free_after;
  logic [3:0]          thr;
  logic [PTR_W:0]      slot_sum;
  logic [PTR_W-1:0]    slot;
  logic [PTR_W-1:0]    head_inc;
  logic                do_push, do_pop, full;
  logic [31:0]         rd_val;
  logic                irq_next;

  function automatic logic [31:0] spread(logic [CHANNELS-1:0] bits, logic odd);
    logic [31:0] v;
    v = '0;
    for (int p = 0; p < CHANNELS; p++) begin
      v[2*p + int'(odd)] = bits[p];
    end
    return v;
  endfunction

  function automatic logic [CHANNELS-1:0] gather(logic [31:0] bus, logic odd);
    logic [CHANNELS-1:0] v;
    for (int p = 0; p < CHANNELS; p++) begin
      v[p] = bus[2*p + int'(odd)];
    end
    return v;
  endfunction

  always_comb begin
    grp       = req.address[9:8];
    gi        = GRP_IW'(grp);
    off       = {req.address[7:2], 2'b00};
    grp_ok    = int'(grp) < GROUPS;
    is_wr     = (req.operation == OP_WRITE);
    in_status = (off >= REG_STATUS) && (off < REG_STATUS + REG_SPAN);
    in_fifo   = (off >= REG_FIFO) && (off < REG_FIFO + REG_SPAN);
    in_thresh = (off >= REG_THRESH) && (off < REG_THRESH + REG_SPAN);
    if (in_status) begin
      rel = off - REG_STATUS;
    end else if (in_fifo) begin
      rel = off - REG_FIFO;
    end else begin
      rel = off - REG_THRESH;
    end
    ch  = CH_W'(rel[7:2]);
    f   = FIFO_W'(int'(grp) * CHANNELS + int'(ch));
    cnt = count[f];
    hd  = head[f];
    full     = (int'(cnt) >= FIFO_DEPTH);
    do_push  = grp_ok && in_fifo && is_wr && !full;
    do_pop   = grp_ok && in_fifo && !is_wr && (cnt != '0);
    cnt_dec  = cnt - CNT_W'(1);
    free_after = (CNT_W+1)'(FIFO_DEPTH) - {1'b0, cnt_dec};
    thr      = 4'd1 << thr_code[f];
    slot_sum = {1'b0, hd} + (PTR_W+1)'(cnt);
    slot     = (int'(slot_sum) >= FIFO_DEPTH) ?
               PTR_W'(slot_sum - (PTR_W+1)'(FIFO_DEPTH)) : PTR_W'(slot_sum);
    head_inc = (int'(hd) == FIFO_DEPTH - 1) ? '0 : hd + PTR_W'(1);
    mem_waddr = MEM_AW'(int'(f) * FIFO_DEPTH + int'(slot));
    mem_raddr = MEM_AW'(int'(f) * FIFO_DEPTH + int'(hd));
    mem_we    = cmd.exec && do_push;
    mem_re    = cmd.exec && do_pop;
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      rd_en_next[g]   = rd_en[g];
      rd_pend_next[g] = rd_pend[g];
      wr_en_next[g]   = wr_en[g];
      wr_pend_next[g] = wr_pend[g];
    end
    rd_val = '0;
    if (grp_ok) begin
      case (off)
        REG_RD_EN: begin
          rd_val = spread(rd_en[gi], 1'b0);
          if (is_wr && cmd.exec) begin
            rd_en_next[gi] = gather(req.write_data, 1'b0);
          end
        end
        REG_RD_PEND: begin
          rd_val = spread(rd_pend[gi], 1'b0);
          if (is_wr && cmd.exec) begin
            rd_pend_next[gi] = rd_pend[gi] & ~gather(req.write_data, 1'b0);
          end
        end
        REG_WR_EN: begin
          rd_val = spread(wr_en[gi], 1'b1);
          if (is_wr && cmd.exec) begin
            wr_en_next[gi] = gather(req.write_data, 1'b1);
          end
        end
        REG_WR_PEND: begin
          rd_val = spread(wr_pend[gi], 1'b1);
          if (is_wr && cmd.exec) begin
            wr_pend_next[gi] = wr_pend[gi] & ~gather(req.write_data, 1'b1);
          end
        end
        default: begin
          if (in_status) begin
            rd_val = 32'(cnt);
          end else if (in_thresh) begin
            rd_val = 32'(thr_code[f]);
          end
        end
      endcase
      if (cmd.exec && do_push) begin
        rd_pend_next[gi][ch] = 1'b1;
      end
      if (cmd.exec && do_pop && ({1'b0, free_after} >= (CNT_W+2)'(thr))) begin
        wr_pend_next[gi][ch] = 1'b1;
      end
    end
    if (is_wr) begin
      rd_val = '0;
    end
    irq_next = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      irq_next = irq_next | (|((rd_en_next[g] & rd_pend_next[g]) |
                               (wr_en_next[g] & wr_pend_next[g])));
    end
  end

  assign status.is_pop   = do_pop;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      words[mem_waddr] <= req.write_data;
    end
    if (mem_re) begin
      mem_q <= words[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NFIFO; i++) begin
        count[i]    <= '0;
        head[i]     <= '0;
        thr_code[i] <= '0;
      end
      for (int g = 0; g < GROUPS; g++) begin
        rd_en[g]   <= '0;
        rd_pend[g] <= '0;
        wr_en[g]   <= '0;
        wr_pend[g] <= '0;
      end
    end else begin
      for (int g = 0; g < GROUPS; g++) begin
        rd_en[g]   <= rd_en_next[g];
        rd_pend[g] <= rd_pend_next[g];
        wr_en[g]   <= wr_en_next[g];
        wr_pend[g] <= wr_pend_next[g];
      end
      if (cmd.exec && do_push) begin
        count[f] <= cnt + CNT_W'(1);
      end
      if (cmd.exec && do_pop) begin
        count[f] <= cnt_dec;
        head[f]  <= head_inc;
      end
      if (cmd.exec && grp_ok && in_thresh && is_wr) begin
        thr_code[f] <= req.write_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.exec && !do_pop) || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !do_pop) begin
      out_data.read_data    <= rd_val;
      out_data.push_dropped <= grp_ok && in_fifo && is_wr && full;
      out_data.irq          <= irq_next;
    end else if (cmd.finish) begin
      out_data.read_data    <= mem_q;
      out_data.push_dropped <= 1'b0;
      out_data.irq          <= irq_next;
    end
  end

endmodule

/* design/message_box_fifo_registers_unit.sv */
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  operation, address, write_data
// out       output     out_valid/out_stall read_data, push_dropped, irq
//
// An access is captured, then executes into its result register; a FIFO pop
// adds a step that waits on the registered read port of the word memory.
// One access is in flight at a time; the next transfer is taken once the
// access has written its result register, so results may wait under stall.
// rst is synchronous and clears counts, pointers, enables, pending bits and
// thresholds; the word memory is not cleared.
module message_box_fifo_registers_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mbfifo_pkg::req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mbfifo_pkg::rsp_t out_data
);
  import mbfifo_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mbfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mbfifo_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/message_box_fifo_checker.sv */
module message_box_fifo_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  mbfifo_pkg::req_t in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  mbfifo_pkg::rsp_t out_data,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbfifo_pkg::*;

  logic [31:0]         fifo_mem    [NFIFO][FIFO_DEPTH];
  logic [CNT_W-1:0]    fifo_fill   [NFIFO];
  logic [PTR_W-1:0]    fifo_rd_ptr [NFIFO];
  logic [1:0]          space_code  [NFIFO];
  logic [CHANNELS-1:0] rd_irq_en   [GROUPS];
  logic [CHANNELS-1:0] rd_irq_pend [GROUPS];
  logic [CHANNELS-1:0] wr_irq_en   [GROUPS];
  logic [CHANNELS-1:0] wr_irq_pend [GROUPS];

  rsp_t awaited_rsp [$];
  int   errors = 0;
  int   waiting = 0;

  assign fail_count  = errors;
  assign outstanding = waiting;

  function automatic logic [31:0] to_bus(logic [CHANNELS-1:0] bits, int odd);
    logic [31:0] v;
    v = '0;
    for (int p = 0; p < CHANNELS; p++)
      if (bits[p]) v[2*p+odd] = 1'b1;
    return v;
  endfunction

  function automatic logic [CHANNELS-1:0] from_bus(logic [31:0] bus, int odd);
    logic [CHANNELS-1:0] v;
    v = '0;
    for (int p = 0; p < CHANNELS; p++)
      v[p] = bus[2*p+odd];
    return v;
  endfunction

  function automatic rsp_t register_access(input req_t acc);
    logic [9:0]  addr;
    logic [31:0] rd;
    logic        is_wr;
    int          g, off, p, f, cnt, hd, thr;
    rsp_t        res;
    is_wr = (acc.operation == OP_WRITE);
    addr  = {acc.address[9:2], 2'b00};
    g     = int'(addr[9:8]);
    off   = int'(addr[7:0]);
    rd    = '0;
    res   = '0;
    if (g < GROUPS) begin
      if (off == REG_RD_EN) begin
        if (is_wr) rd_irq_en[g] = from_bus(acc.write_data, 0);
        else rd = to_bus(rd_irq_en[g], 0);
      end else if (off == REG_RD_PEND) begin
        if (is_wr) rd_irq_pend[g] &= ~from_bus(acc.write_data, 0);
        else rd = to_bus(rd_irq_pend[g], 0);
      end else if (off == REG_WR_EN) begin
        if (is_wr) wr_irq_en[g] = from_bus(acc.write_data, 1);
        else rd = to_bus(wr_irq_en[g], 1);
      end else if (off == REG_WR_PEND) begin
        if (is_wr) wr_irq_pend[g] &= ~from_bus(acc.write_data, 1);
        else rd = to_bus(wr_irq_pend[g], 1);
      end else if (off >= REG_STATUS && off < REG_STATUS + REG_SPAN) begin
        f = g * CHANNELS + (off - REG_STATUS) / 4;
        if (!is_wr) rd = 32'(fifo_fill[f]) & 32'hF;
      end else if (off >= REG_FIFO && off < REG_FIFO + REG_SPAN) begin
        p   = (off - REG_FIFO) / 4;
        f   = g * CHANNELS + p;
        cnt = int'(fifo_fill[f]);
        hd  = int'(fifo_rd_ptr[f]);
        if (is_wr) begin
          if (cnt >= FIFO_DEPTH) begin
            res.push_dropped = 1'b1;
          end else begin
            fifo_mem[f][(hd + cnt) % FIFO_DEPTH] = acc.write_data;
            fifo_fill[f] = CNT_W'(cnt + 1);
            rd_irq_pend[g][p] = 1'b1;
          end
        end else if (cnt > 0) begin
          thr = 1 << space_code[f];
          rd  = fifo_mem[f][hd];
          fifo_rd_ptr[f] = PTR_W'((hd + 1) % FIFO_DEPTH);
          cnt = cnt - 1;
          fifo_fill[f] = CNT_W'(cnt);
          if (FIFO_DEPTH - cnt >= thr) wr_irq_pend[g][p] = 1'b1;
        end
      end else if (off >= REG_THRESH && off < REG_THRESH + REG_SPAN) begin
        f = g * CHANNELS + (off - REG_THRESH) / 4;
        if (is_wr) space_code[f] = acc.write_data[1:0];
        else rd = 32'(space_code[f]);
      end
    end
    res.read_data = is_wr ? '0 : rd;
    res.irq = 1'b0;
    for (int n = 0; n < GROUPS; n++)
      if (((rd_irq_en[n] & rd_irq_pend[n]) | (wr_irq_en[n] & wr_irq_pend[n])) != '0)
        res.irq = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int f = 0; f < NFIFO; f++) begin
        fifo_fill[f]   = '0;
        fifo_rd_ptr[f] = '0;
        space_code[f]  = '0;
      end
      for (int g = 0; g < GROUPS; g++) begin
        rd_irq_en[g]   = '0;
        rd_irq_pend[g] = '0;
        wr_irq_en[g]   = '0;
        wr_irq_pend[g] = '0;
      end
      awaited_rsp.delete();
    end else begin
      if (in_valid && !in_stall) awaited_rsp.push_back(register_access(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none actual %h", $time, out_data);
        end else begin
          want = awaited_rsp.pop_front();
          if (out_data.read_data !== want.read_data) begin
            errors++;
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, out_data.read_data);
          end
          if (out_data.push_dropped !== want.push_dropped) begin
            errors++;
            $display("%0t: push_dropped expected %b actual %b", $time,
                     want.push_dropped, out_data.push_dropped);
          end
          if (out_data.irq !== want.irq) begin
            errors++;
            $display("%0t: irq expected %b actual %b", $time, want.irq, out_data.irq);
          end
        end
      end
    end
    waiting = awaited_rsp.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbfifo_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  int   fail_count;
  int   outstanding;

  message_box_fifo_registers_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  message_box_fifo_checker access_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("message_box_fifo_registers_unit verification failed");
    $finish;
  end

  function automatic req_t bus_op(logic op, logic [9:0] addr, logic [31:0] data);
    req_t r;
    r.operation  = op;
    r.address    = addr;
    r.write_data = data;
    return r;
  endfunction

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic req_t random_access(int push_pct);
    req_t       r;
    int         pick, g, ch;
    logic [7:0] off;
    pick = $urandom_range(0, 99);
    g    = $urandom_range(0, GROUPS - 1);
    ch   = $urandom_range(0, 1) ? 0 : $urandom_range(0, CHANNELS - 1);
    r.write_data = $urandom;
    r.operation  = logic'($urandom_range(0, 1));
    if (pick < 40) begin
      off = 8'(REG_FIFO + 4 * ch);
      r.operation = ($urandom_range(0, 99) < push_pct) ? OP_WRITE : OP_READ;
    end else if (pick < 48) begin
      off = 8'(REG_STATUS + 4 * ch);
    end else if (pick < 58) begin
      off = 8'(REG_THRESH + 4 * ch);
    end else if (pick < 76) begin
      case ($urandom_range(0, 3))
        0: off = REG_RD_EN;
        1: off = REG_RD_PEND;
        2: off = REG_WR_EN;
        default: off = REG_WR_PEND;
      endcase
    end else if (pick < 84) begin
      g   = $urandom_range(GROUPS, 3);
      off = 8'($urandom_range(0, 255));
    end else begin
      g   = $urandom_range(0, 3);
      off = 8'($urandom_range(0, 255));
    end
    r.address = {g[1:0], off[7:2], 2'($urandom_range(0, 3))};
    return r;
  endfunction

  task automatic transfer(input req_t r, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : receiver
    int   cyc, len, pick, long_holds;
    logic hold;
    cyc = 0;
    long_holds = 0;
    forever begin
      if ((cyc > 1000 && long_holds == 0) || (cyc > 3000 && long_holds == 1)) begin
        hold = 1'b1;
        len  = 150;
        long_holds++;
      end else if (cyc % 400 < 80) begin
        hold = 1'b0;
        len  = 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          hold = 1'b0;
          len  = $urandom_range(1, 4);
        end else if (pick < 92) begin
          hold = 1'b1;
          len  = $urandom_range(1, 3);
        end else begin
          hold = 1'b1;
          len  = $urandom_range(8, 30);
        end
      end
      @(negedge clk);
      out_stall <= hold;
      repeat (len - 1) @(negedge clk);
      cyc += len;
    end
  end

  initial begin : stimulus
    int push_pct;
    push_pct = 50;
    while (rst) @(negedge clk);

    transfer(bus_op(OP_WRITE, 10'h020, 32'hFFFF_FFFF), 0);
    transfer(bus_op(OP_WRITE, 10'h030, 32'hFFFF_FFFF), 0);
    transfer(bus_op(OP_WRITE, 10'h130, 32'hFFFF_FFFF), 1);
    transfer(bus_op(OP_WRITE, 10'h080, 32'h0000_0003), 0);
    // fill channel 0 and push once more into the full FIFO
    for (int i = 0; i <= FIFO_DEPTH; i++)
      transfer(bus_op(OP_WRITE, 10'h070,
                      (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom), i % 2);
    transfer(bus_op(OP_READ, 10'h060, $urandom), 0);
    transfer(bus_op(OP_READ, 10'h024, $urandom), 0);
    transfer(bus_op(OP_WRITE, 10'h024, 32'hFFFF_FFFF), 2);
    // drain, then pop the empty FIFO
    for (int i = 0; i <= FIFO_DEPTH; i++)
      transfer(bus_op(OP_READ, 10'h070, $urandom), i % 3);
    transfer(bus_op(OP_READ, 10'h034, $urandom), 0);
    transfer(bus_op(OP_WRITE, 10'h064, 32'hFFFF_FFFF), 0);
    transfer(bus_op(OP_READ, 10'h3F3, $urandom), 0);
    transfer(bus_op(OP_READ, 10'h000, $urandom), 0);

    for (int i = 0; i < 800; i++) begin
      if (i % 60 == 0) push_pct = $urandom_range(0, 1) ? 80 : 25;
      if (i == 400) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      transfer(random_access(push_pct), (i % 100 < 20) ? 0 : idle_len());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("message_box_fifo_registers_unit verification clean");
    else
      $display("message_box_fifo_registers_unit verification failed");
    $finish;
  end

endmodule
